[design/ray_plane_intersect_unit_macros.svh]
// Assertion helpers shared by the ray/plane intersection design.
`ifndef RAY_PLANE_INTERSECT_UNIT_MACROS_SVH
`define RAY_PLANE_INTERSECT_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RPI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RPI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rpi_pkg.sv]
package rpi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DEN_W = 52;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W = 3;
	localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [30:0] nearest_distance;
	} ray_t;

	typedef struct packed {
		logic hit;
		logic [30:0] hit_distance;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} result_t;

	typedef struct packed {
		logic signed [17:0] normal_x;
		logic signed [17:0] normal_y;
		logic signed [17:0] normal_z;
		logic signed [31:0] plane_offset;
	} cfg_t;

	// Handshake between the front end and the queue.
	typedef struct packed {
		logic valid;
		logic ready;
	} link_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

[design/rpi_front.sv]
module rpi_front #(
	parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rpi_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_stall,
	input  rpi_pkg::ray_t in_data,
	output rpi_pkg::link_t link_out,
	input  logic queue_ready,
	output rpi_pkg::ray_t ray_out,
	output logic nohit_out,
	output logic [((FRAC_BITS + 34 > rpi_pkg::DEN_W) ? FRAC_BITS + 34 : rpi_pkg::DEN_W)-1:0]
		a_out,
	output logic [rpi_pkg::DEN_W-1:0] b_out
);

	localparam int NUM_W = (FRAC_BITS + 34 > rpi_pkg::DEN_W) ? FRAC_BITS + 34 : rpi_pkg::DEN_W;
	localparam int DW = rpi_pkg::DEN_W;

	logic f_adv;
	logic signed [17:0] n [3];
	logic signed [31:0] o [3];
	logic signed [31:0] d [3];

	logic v_s1, v_s2, v_s3;
	logic signed [49:0] pno_s1 [3];
	logic signed [49:0] pnd_s1 [3];
	logic signed [31:0] off_s1;
	rpi_pkg::ray_t ray_s1, ray_s2, ray_s3;
	logic signed [NUM_W-1:0] num_s2;
	logic signed [DW-1:0] den_s2;
	logic nohit_s3;
	logic [NUM_W-1:0] a_s3;
	logic [DW-1:0] b_s3;

	// The last stage holds its item until the queue has room.
	assign f_adv = !v_s3 || queue_ready;
	assign in_stall = !f_adv;

	assign n[0] = cfg.normal_x;
	assign n[1] = cfg.normal_y;
	assign n[2] = cfg.normal_z;
	assign o[0] = in_data.origin_x;
	assign o[1] = in_data.origin_y;
	assign o[2] = in_data.origin_z;
	assign d[0] = in_data.dir_x;
	assign d[1] = in_data.dir_y;
	assign d[2] = in_data.dir_z;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		always_ff @(posedge clk) begin
			if (f_adv) begin
				pno_s1[k] <= n[k] * o[k];
				pnd_s1[k] <= n[k] * d[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (f_adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (f_adv) begin
			off_s1 <= cfg.plane_offset;
			ray_s1 <= in_data;
			ray_s2 <= ray_s1;
			ray_s3 <= ray_s2;
			den_s2 <= DW'(pnd_s1[0]) + DW'(pnd_s1[1]) + DW'(pnd_s1[2]);
			num_s2 <= -(NUM_W'(pno_s1[0]) + NUM_W'(pno_s1[1]) + NUM_W'(pno_s1[2])
				+ (NUM_W'(off_s1) <<< FRAC_BITS));
			// Parallel rays and rays facing away from the plane never hit.
			nohit_s3 <= (den_s2 == '0) || (num_s2 == '0) || (num_s2[NUM_W-1] != den_s2[DW-1]);
			a_s3 <= num_s2[NUM_W-1] ? NUM_W'(-num_s2) : NUM_W'(num_s2);
			b_s3 <= den_s2[DW-1] ? DW'(-den_s2) : DW'(den_s2);
		end
	end

	assign link_out.valid = v_s3;
	assign link_out.ready = f_adv;
	assign ray_out = ray_s3;
	assign nohit_out = nohit_s3;
	assign a_out = a_s3;
	assign b_out = b_s3;

endmodule

[design/rpi_fifo.sv]
module rpi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rpi_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] wdata,
	output logic full,
	input  logic pop,
	output logic empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && !empty);
		end
	end

`include "ray_plane_intersect_unit_macros.svh"

	`RPI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "queue count exceeds depth")
	`RPI_ASSERT_NXT(a_cnt_grow, push && !full && !(pop && !empty), cnt_q == $past(cnt_q) + 1'b1,
		"queue count did not grow on push")

endmodule

[design/rpi_back.sv]
module rpi_back #(
	parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_pop,
	input  rpi_pkg::ray_t item_ray,
	input  logic item_nohit,
	input  logic [((FRAC_BITS + 34 > rpi_pkg::DEN_W) ? FRAC_BITS + 34 : rpi_pkg::DEN_W)-1:0]
		item_a,
	input  logic [rpi_pkg::DEN_W-1:0] item_b,
	output logic out_valid,
	input  logic out_stall,
	output rpi_pkg::result_t out_data
);

	localparam int NUM_W = (FRAC_BITS + 34 > rpi_pkg::DEN_W) ? FRAC_BITS + 34 : rpi_pkg::DEN_W;
	localparam int DW = rpi_pkg::DEN_W;
	localparam int QB = 31;
	localparam int RW = DW + QB;
	localparam int CMPW = NUM_W + QB + FRAC_BITS;

	logic b_adv;
	logic out_valid_q;
	rpi_pkg::result_t out_data_q;

	logic v_s [QB+1];
	logic [RW-1:0] rem_s [QB+1];
	logic [DW-1:0] bden_s [QB+1];
	logic [30:0] quo_s [QB+1];
	logic ovf_s [QB+1];
	logic nohit_s [QB+1];
	rpi_pkg::ray_t ray_s [QB+1];

	logic [30:0] q_fin;
	logic hit_fin;
	logic signed [31:0] dvec [3];

	logic v_m, hit_m;
	logic [30:0] q_m;
	logic signed [63:0] prod_m [3];
	logic signed [31:0] org_m [3];
	logic signed [31:0] pt [3];

	// Everything behind the queue moves together whenever the result register frees up.
	assign b_adv = !out_valid_q || !out_stall;
	assign item_pop = b_adv && item_valid;

	// Entry stage: detect a quotient that saturates and start the remainder at a * 2^F.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (b_adv) begin
			v_s[0] <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (b_adv) begin
			rem_s[0] <= RW'(RW'(item_a) << FRAC_BITS);
			bden_s[0] <= item_b;
			quo_s[0] <= '0;
			ovf_s[0] <= (CMPW'(item_a) << FRAC_BITS) >= (CMPW'(item_b) << QB);
			nohit_s[0] <= item_nohit;
			ray_s[0] <= item_ray;
		end
	end

	// One restoring-division step per stage, most significant quotient bit first.
	for (genvar k = 1; k <= QB; k++) begin : g_div
		localparam int BIT = QB - k;
		logic [RW:0] trial;
		assign trial = {1'b0, rem_s[k-1]} - {1'b0, RW'(RW'(bden_s[k-1]) << BIT)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (b_adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (b_adv) begin
				rem_s[k] <= trial[RW] ? rem_s[k-1] : trial[RW-1:0];
				quo_s[k] <= quo_s[k-1] | (31'(!trial[RW]) << BIT);
				bden_s[k] <= bden_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				nohit_s[k] <= nohit_s[k-1];
				ray_s[k] <= ray_s[k-1];
			end
		end
	end

	assign q_fin = ovf_s[QB] ? rpi_pkg::T_MAX : quo_s[QB];
	assign hit_fin = !nohit_s[QB] && (q_fin != '0) && (q_fin < ray_s[QB].nearest_distance);
	assign dvec[0] = ray_s[QB].dir_x;
	assign dvec[1] = ray_s[QB].dir_y;
	assign dvec[2] = ray_s[QB].dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (b_adv) begin
			v_m <= v_s[QB];
			out_valid_q <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (b_adv) begin
			hit_m <= hit_fin;
			q_m <= q_fin;
			org_m[0] <= ray_s[QB].origin_x;
			org_m[1] <= ray_s[QB].origin_y;
			org_m[2] <= ray_s[QB].origin_z;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_pt
		always_ff @(posedge clk) begin
			if (b_adv) begin
				prod_m[k] <= $signed({1'b0, q_fin}) * dvec[k];
			end
		end
		// Arithmetic shift right rounds toward minus infinity.
		assign pt[k] = rpi_pkg::sat32(64'(org_m[k]) + (prod_m[k] >>> FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (b_adv) begin
			out_data_q.hit <= hit_m;
			out_data_q.hit_distance <= hit_m ? q_m : '0;
			out_data_q.point_x <= hit_m ? pt[0] : '0;
			out_data_q.point_y <= hit_m ? pt[1] : '0;
			out_data_q.point_z <= hit_m ? pt[2] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

[design/ray_plane_intersect_unit.sv]
// Path from an accepted ray to its result on the output register: 3 front-end stages,
// the queue, then the back-end restoring divider and output stages; stalls add to it.
// Throughput: one ray per cycle unless stalled, set by the 31-stage pipelined divider.
// Reset (arst_n low, asynchronous): pipelines and queue empty, plane normal (0, 0, 1),
// plane offset zero. No clearing pass; the block takes rays right after reset.
module ray_plane_intersect_unit #(
	parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  rpi_pkg::ray_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rpi_pkg::result_t out_data
);

	localparam int NUM_W = (FRAC_BITS + 34 > rpi_pkg::DEN_W) ? FRAC_BITS + 34 : rpi_pkg::DEN_W;
	localparam int DW = rpi_pkg::DEN_W;
	localparam int RAY_W = $bits(rpi_pkg::ray_t);
	localparam int ENT_W = 1 + NUM_W + DW + RAY_W;

	rpi_pkg::cfg_t cfg_q;
	rpi_pkg::link_t f_link;
	logic q_full, q_empty, q_pop;
	rpi_pkg::ray_t f_ray, b_ray;
	logic f_nohit, b_nohit;
	logic [NUM_W-1:0] f_a, b_a;
	logic [DW-1:0] f_b, b_b;
	logic [ENT_W-1:0] q_wdata, q_rdata;

	// Configuration writes are always taken; unknown indexes fall through untouched.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x <= 18'sd0;
			cfg_q.normal_y <= 18'sd0;
			cfg_q.normal_z <= 18'sd65536;
			cfg_q.plane_offset <= 32'sd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rpi_pkg::REG_NORMAL_X: begin
					cfg_q.normal_x <= cfg_data[17:0];
				end
				rpi_pkg::REG_NORMAL_Y: begin
					cfg_q.normal_y <= cfg_data[17:0];
				end
				rpi_pkg::REG_NORMAL_Z: begin
					cfg_q.normal_z <= cfg_data[17:0];
				end
				rpi_pkg::REG_PLANE_OFFSET: begin
					cfg_q.plane_offset <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// The front end forms the numerator and denominator and flags rays that cannot hit.
	rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.link_out(f_link),
		.queue_ready(!q_full),
		.ray_out(f_ray),
		.nohit_out(f_nohit),
		.a_out(f_a),
		.b_out(f_b)
	);

	// A short queue lets the front end keep accepting while the back end is held.
	assign q_wdata = {f_nohit, f_a, f_b, f_ray};
	assign {b_nohit, b_a, b_b, b_ray} = q_rdata;

	rpi_fifo #(.WIDTH(ENT_W), .DEPTH(rpi_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_link.valid),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.empty(q_empty),
		.rdata(q_rdata)
	);

	// The back end divides, checks the nearest distance and forms the hit point.
	rpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(!q_empty),
		.item_pop(q_pop),
		.item_ray(b_ray),
		.item_nohit(b_nohit),
		.item_a(b_a),
		.item_b(b_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

`include "ray_plane_intersect_unit_macros.svh"

	`RPI_ASSERT_IMP(a_miss_zero, out_valid && !out_data.hit,
		out_data.hit_distance == '0 && out_data.point_x == '0 && out_data.point_y == '0
		&& out_data.point_z == '0, "miss transaction carries nonzero fields")
	`RPI_ASSERT_IMP(a_hit_dist, out_valid && out_data.hit,
		out_data.hit_distance != '0 && out_data.hit_distance != rpi_pkg::T_MAX,
		"hit transaction with zero or saturated distance")
	`RPI_ASSERT_IMP(a_front_hold, f_link.valid && q_full, in_stall,
		"front end accepts while its last stage is blocked")

endmodule
